FILE: sv/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Widths, constants, the reciprocal table and the fixed-point multiply
// helpers of the Taylor-series sine pipeline.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int ANGLE_W   = 32;
    localparam int MAG_W     = 32;
    localparam int X2_W      = 35;
    localparam int F_W       = 32;
    localparam int M_W       = 37;
    localparam int ACC_W     = 41;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 30;
    localparam int FRAC_BITS = 28;
    localparam int LO_W      = 32;

    localparam logic [CNT_W-1:0] TERM_COUNT_RST = CNT_W'(5);

    localparam logic [ANGLE_W-1:0] Q_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic [ANGLE_W-1:0] Q_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0] SUM_MAX =
        $signed({{(ACC_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SUM_MIN =
        $signed({{(ACC_W-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}});

    typedef struct packed {
        logic [X2_W-1:0]         x2;
        logic [F_W-1:0]          f;
        logic [M_W-1:0]          m;
        logic signed [ACC_W-1:0] acc;
        logic                    neg;
        logic                    last;
    } term_data_t;

    // round(2^32 / ((2k)(2k+1))) for k = 1 .. 8
    function automatic logic [RECIP_W-1:0] recip_pair(input int idx);
        logic [RECIP_W-1:0] r;
        unique case (idx)
            0:       r = RECIP_W'(715827883);
            1:       r = RECIP_W'(214748365);
            2:       r = RECIP_W'(102261126);
            3:       r = RECIP_W'(59652324);
            4:       r = RECIP_W'(39045157);
            5:       r = RECIP_W'(27531842);
            6:       r = RECIP_W'(20452225);
            7:       r = RECIP_W'(15790321);
            default: r = '0;
        endcase
        return r;
    endfunction

    // round(x2 * r / 2^32)
    function automatic logic [F_W-1:0] mul_recip(input logic [X2_W-1:0] x2,
                                                 input logic [RECIP_W-1:0] r);
        logic [63:0] lo_p;
        logic [32:0] hi_p;
        logic [64:0] tot;
        lo_p = 64'(x2[LO_W-1:0]) * 64'(r);
        hi_p = 33'(x2[X2_W-1:LO_W]) * 33'(r);
        tot  = 65'(lo_p) + (65'(hi_p) << LO_W) + (65'd1 << (LO_W-1));
        return tot[LO_W+F_W-1:LO_W];
    endfunction

    // round(m * f / 2^28), split at bit 32 of m
    function automatic logic [M_W-1:0] mul_q28(input logic [M_W-1:0] m,
                                               input logic [F_W-1:0] f);
        logic [63:0] lo_p;
        logic [63:0] lo_r;
        logic [36:0] hi_p;
        logic [40:0] tot;
        lo_p = 64'(m[LO_W-1:0]) * 64'(f);
        lo_r = lo_p + (64'd1 << (FRAC_BITS-1));
        hi_p = 37'(m[M_W-1:LO_W]) * 37'(f);
        tot  = (41'(hi_p) << (LO_W-FRAC_BITS)) + 41'(lo_r[63:FRAC_BITS]);
        return tot[M_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/sts_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_term
// One series stage: next magnitude, next ratio and the running sum update.
// ----------------------------------------------------------------------------
module sts_term import sts_pkg::*; #(
    parameter int K = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ld,
    input  wire logic             vld_in,
    input  wire logic [CNT_W-1:0] cnt,
    input  wire term_data_t       din,
    output logic                  vld_out,
    output term_data_t            dout
);

    localparam bit SUB = (K % 2 == 0);

    logic                    vld_reg;
    term_data_t              data_reg;
    term_data_t              data_next;
    logic                    add_en;
    logic signed [ACC_W-1:0] m_ext;

    // previous term k-1 joins the sum here
    assign add_en = (K > 1) && (CNT_W'(K-1) <= cnt);
    assign m_ext  = $signed({{(ACC_W-M_W){1'b0}}, din.m});

    always_comb begin
        data_next      = din;
        data_next.m    = mul_q28(din.m, din.f);
        data_next.f    = mul_recip(din.x2, recip_pair(K));
        if (add_en) begin
            data_next.acc = SUB ? (din.acc - m_ext) : (din.acc + m_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ld) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            data_reg <= data_next;
        end
    end

    assign vld_out = vld_reg;
    assign dout    = data_reg;

endmodule
`default_nettype wire

FILE: sv/sine_taylor_series_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_taylor_series_top
// Truncated Taylor-series sine on signed Q3.28 samples, saturating output.
//
//   channel   direction  payload
//   s_axis    in         tdata = angle, tlast = is_last_in
//   m_axis    out        tdata = sine_value, tuser = saturated, tlast
//   cfg       in         cfg_data = term_count
//
// one item per cycle while the output is not stalled; one stage per series term
// plus input, square, first ratio, final add and saturation stages
// each stage holds its item while the stage after it is full and stalled
// synchronous active-low reset clears all valid bits and sets term_count to 5
// ----------------------------------------------------------------------------
module sine_taylor_series_top import sts_pkg::*; #(
    parameter int MAX_TERMS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [ANGLE_W-1:0] s_axis_tdata,   // [31:0] angle
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [ANGLE_W-1:0]      m_axis_tdata,   // [31:0] sine_value
    output logic [0:0]              m_axis_tuser,   // [0] saturated
    output logic                    m_axis_tlast,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   cfg_data
);

    localparam int NS     = MAX_TERMS + 5;
    localparam int ST_X2  = 1;
    localparam int ST_F   = 2;
    localparam int ST_FA  = MAX_TERMS + 3;
    localparam int ST_OUT = MAX_TERMS + 4;
    localparam bit LAST_SUB = (MAX_TERMS % 2 == 1);

    logic [NS-1:0] stage_v;
    logic [NS-1:0] ld;

    logic [CNT_W-1:0] term_count_reg;
    logic [CNT_W-1:0] cnt_eff;

    logic               v0_reg, v1_reg, v2_reg, vfa_reg, vout_reg;
    logic [MAG_W-1:0]   mag0_reg, mag0_next;
    logic               neg0_reg, last0_reg;
    logic [MAG_W-1:0]   mag1_reg;
    logic [X2_W-1:0]    x21_reg, x21_next;
    logic               neg1_reg, last1_reg;
    term_data_t         td2_reg, td2_next;
    term_data_t         td [0:MAX_TERMS];

    logic signed [ACC_W-1:0] accfa_reg, accfa_next;
    logic                    negfa_reg, lastfa_reg;
    logic signed [ACC_W-1:0] m_last_ext;

    logic signed [ACC_W-1:0] sum;
    logic [ANGLE_W-1:0]      out_data_reg, out_data_next;
    logic                    out_sat_reg, out_sat_next;
    logic                    out_last_reg;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= TERM_COUNT_RST;
        end else if (cfg_valid) begin
            term_count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign cnt_eff   = (term_count_reg > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                              : term_count_reg;

    // ready chain
    assign ld[NS-1] = !stage_v[NS-1] || m_axis_tready;
    for (genvar i = 0; i < NS - 1; i++) begin : g_ld
        assign ld[i] = !stage_v[i] || ld[i+1];
    end

    assign s_axis_tready = ld[0];

    assign stage_v[0]      = v0_reg;
    assign stage_v[ST_X2]  = v1_reg;
    assign stage_v[ST_F]   = v2_reg;
    assign stage_v[ST_FA]  = vfa_reg;
    assign stage_v[ST_OUT] = vout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vfa_reg  <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (ld[0])      v0_reg   <= s_axis_tvalid;
            if (ld[ST_X2])  v1_reg   <= v0_reg;
            if (ld[ST_F])   v2_reg   <= v1_reg;
            if (ld[ST_FA])  vfa_reg  <= stage_v[ST_FA-1];
            if (ld[ST_OUT]) vout_reg <= vfa_reg;
        end
    end

    // input stage: magnitude and sign
    assign mag0_next = s_axis_tdata[ANGLE_W-1] ? ((~s_axis_tdata) + ANGLE_W'(1))
                                               : s_axis_tdata;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            mag0_reg  <= mag0_next;
            neg0_reg  <= s_axis_tdata[ANGLE_W-1];
            last0_reg <= s_axis_tlast;
        end
    end

    // square stage
    always_comb begin
        logic [63:0] sq;
        sq       = 64'(mag0_reg) * 64'(mag0_reg) + (64'd1 << (FRAC_BITS-1));
        x21_next = sq[FRAC_BITS+X2_W-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_X2]) begin
            mag1_reg  <= mag0_reg;
            x21_reg   <= x21_next;
            neg1_reg  <= neg0_reg;
            last1_reg <= last0_reg;
        end
    end

    // first ratio stage
    always_comb begin
        td2_next.x2   = x21_reg;
        td2_next.f    = mul_recip(x21_reg, recip_pair(0));
        td2_next.m    = M_W'(mag1_reg);
        td2_next.acc  = $signed({{(ACC_W-MAG_W){1'b0}}, mag1_reg});
        td2_next.neg  = neg1_reg;
        td2_next.last = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_F]) begin
            td2_reg <= td2_next;
        end
    end

    assign td[0] = td2_reg;

    // series stages
    for (genvar k = 1; k <= MAX_TERMS; k++) begin : g_term
        sts_term #(
            .K (k)
        ) u_term (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ld      (ld[ST_F+k]),
            .vld_in  (stage_v[ST_F+k-1]),
            .cnt     (cnt_eff),
            .din     (td[k-1]),
            .vld_out (stage_v[ST_F+k]),
            .dout    (td[k])
        );
    end

    // final add of the last term
    assign m_last_ext = $signed({{(ACC_W-M_W){1'b0}}, td[MAX_TERMS].m});

    always_comb begin
        accfa_next = td[MAX_TERMS].acc;
        if (CNT_W'(MAX_TERMS) <= cnt_eff) begin
            accfa_next = LAST_SUB ? (td[MAX_TERMS].acc - m_last_ext)
                                  : (td[MAX_TERMS].acc + m_last_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_FA]) begin
            accfa_reg  <= accfa_next;
            negfa_reg  <= td[MAX_TERMS].neg;
            lastfa_reg <= td[MAX_TERMS].last;
        end
    end

    // sign and saturation
    always_comb begin
        sum = negfa_reg ? -accfa_reg : accfa_reg;
        if (sum > SUM_MAX) begin
            out_data_next = Q_MAX;
            out_sat_next  = 1'b1;
        end else if (sum < SUM_MIN) begin
            out_data_next = Q_MIN;
            out_sat_next  = 1'b1;
        end else begin
            out_data_next = sum[ANGLE_W-1:0];
            out_sat_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_OUT]) begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
            out_last_reg <= lastfa_reg;
        end
    end

    assign m_axis_tvalid   = vout_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_sat_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule
`default_nettype wire

FILE: sv/sts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the sine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker import sts_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_axis_tready,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [ANGLE_W-1:0] m_axis_tdata,
    input wire logic [0:0]         m_axis_tuser,
    input wire logic               m_axis_tlast
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // empty output stage never blocks the input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    // saturated results sit at a range end
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata == Q_MAX || m_axis_tdata == Q_MIN))
        else $error("saturated item not at range end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result item changed");

endmodule

bind sine_taylor_series_top sts_checker u_sts_checker (.*);
`default_nettype wire
